// File: rtl/core/rpe_pkg.sv
package rpe_pkg;

  localparam int DATA_W = 32;

  // character codes
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  // operator codes
  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  // error codes
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_UNDERFLOW = 2'd1;
  localparam logic [1:0] ERR_OVERFLOW  = 2'd2;
  localparam logic [1:0] ERR_DIVZERO   = 2'd3;

  // controller to datapath commands
  typedef struct packed {
    logic       acc_digit;
    logic       push_acc;
    logic       push_zero;
    logic       rd_sel;
    logic       lat_right;
    logic       lat_left;
    logic       exec;
    logic       div_start;
    logic       div_fix;
    logic       wb;
    logic       emit;
    logic [1:0] op;
    logic [3:0] digit;
  } rpe_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic sp_lt2;
    logic div_done;
  } rpe_sts_t;

endpackage

// File: rtl/core/rpe_ram.sv
module rpe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/rpe_div.sv
module rpe_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [rpe_pkg::DATA_W-1:0] num,
  input  logic [rpe_pkg::DATA_W-1:0] den,
  output logic                      done,
  output logic [rpe_pkg::DATA_W-1:0] quot
);

  import rpe_pkg::*;

  localparam int CNT_W = $clog2(DATA_W);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] quo;
  logic [DATA_W-1:0] ud;
  logic              neg;
  logic [DATA_W:0]   trial;

  // one restoring step per cycle
  assign trial = {rem, quo[DATA_W-1]} - {1'b0, ud};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CNT_W'(DATA_W - 1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(DATA_W - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // magnitudes and partial remainder
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= num[DATA_W-1] ? (DATA_W'(0) - num) : num;
      ud  <= den[DATA_W-1] ? (DATA_W'(0) - den) : den;
      neg <= num[DATA_W-1] ^ den[DATA_W-1];
    end else if (busy) begin
      if (!trial[DATA_W]) begin
        rem <= trial[DATA_W-1:0];
        quo <= {quo[DATA_W-2:0], 1'b1};
      end else begin
        rem <= {rem[DATA_W-2:0], quo[DATA_W-1]};
        quo <= {quo[DATA_W-2:0], 1'b0};
      end
    end
  end

  // sign of the truncated quotient
  assign quot = neg ? (DATA_W'(0) - quo) : quo;

endmodule

// File: rtl/core/rpe_dp.sv
module rpe_dp #(
  parameter int STACK_DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  rpe_pkg::rpe_cmd_t          cmd,
  output rpe_pkg::rpe_sts_t          sts,
  output logic signed [rpe_pkg::DATA_W-1:0] value,
  output logic [1:0]                 error_code
);

  import rpe_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int SW = $clog2(STACK_DEPTH + 1);

  logic [DATA_W-1:0] acc;
  logic [SW-1:0]     sp;
  logic [1:0]        err;
  logic [DATA_W-1:0] right;
  logic [DATA_W-1:0] left;
  logic [DATA_W-1:0] res;

  logic              full;
  logic [SW-1:0]     sp_m1;
  logic [SW-1:0]     sp_m2;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [DATA_W-1:0] wdata;
  logic [AW-1:0]     raddr;
  logic [DATA_W-1:0] rdata;
  logic [DATA_W-1:0] quot;
  logic              div_done;
  logic [1:0]        raise;

  assign full  = (sp >= SW'(STACK_DEPTH));
  assign sp_m1 = sp - SW'(1);
  assign sp_m2 = sp - SW'(2);

  // operand stack memory
  always_comb begin
    we    = 1'b0;
    waddr = sp[AW-1:0];
    wdata = acc;
    if (cmd.push_acc) begin
      we = !full;
    end else if (cmd.push_zero) begin
      we    = 1'b1;
      waddr = '0;
      wdata = '0;
    end else if (cmd.wb) begin
      we    = 1'b1;
      waddr = sp_m2[AW-1:0];
      wdata = res;
    end
  end

  assign raddr = cmd.rd_sel ? sp_m2[AW-1:0] : sp_m1[AW-1:0];

  rpe_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  rpe_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (left),
    .den   (right),
    .done  (div_done),
    .quot  (quot)
  );

  assign sts.sp_lt2   = (sp < SW'(2));
  assign sts.div_done = div_done;

  // error source of this cycle
  always_comb begin
    raise = ERR_NONE;
    if (cmd.push_acc && full) begin
      raise = ERR_OVERFLOW;
    end else if (cmd.push_zero) begin
      raise = ERR_UNDERFLOW;
    end else if (cmd.div_fix && (right == '0)) begin
      raise = ERR_DIVZERO;
    end
  end

  // accumulator, stack pointer and sticky error
  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
      sp  <= '0;
      err <= ERR_NONE;
    end else begin
      if (cmd.emit) begin
        acc <= '0;
        sp  <= '0;
        err <= ERR_NONE;
      end else begin
        if (cmd.acc_digit) begin
          acc <= (acc << 3) + (acc << 1) + DATA_W'(cmd.digit);
        end else if (cmd.push_acc) begin
          acc <= '0;
        end
        if (cmd.push_acc && !full) begin
          sp <= sp + SW'(1);
        end else if (cmd.push_zero) begin
          sp <= SW'(1);
        end else if (cmd.wb) begin
          sp <= sp_m1;
        end
        if ((err == ERR_NONE) && (raise != ERR_NONE)) begin
          err <= raise;
        end
      end
    end
  end

  // operands, result and output transaction payload
  always_ff @(posedge clk) begin
    if (cmd.lat_right) begin
      right <= rdata;
    end
    if (cmd.lat_left) begin
      left <= rdata;
    end
    if (cmd.exec) begin
      case (cmd.op)
        OP_ADD:  res <= left + right;
        OP_SUB:  res <= left - right;
        OP_MUL:  res <= left * right;
        default: res <= '0;
      endcase
    end else if (cmd.div_fix) begin
      res <= (right == '0) ? '0 : quot;
    end
    if (cmd.emit) begin
      value      <= (sp != '0) ? $signed(rdata) : '0;
      error_code <= err;
    end
  end

`ifndef NO_ASSERTIONS
  a_sp_bound: assert property (@(posedge clk) disable iff (rst)
    sp <= SW'(STACK_DEPTH))
    else $error("stack pointer beyond depth");

  a_wb_pop: assert property (@(posedge clk) disable iff (rst)
    cmd.wb |=> sp == $past(sp) - SW'(1))
    else $error("write back did not leave one fewer entry");

  a_emit_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> (sp == '0) && (err == ERR_NONE) && (acc == '0))
    else $error("state not cleared after end mark");
`endif

endmodule

// File: rtl/core/rpe_ctrl.sv
module rpe_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        char_code,
  output logic              out_valid,
  input  logic              out_stall,
  input  rpe_pkg::rpe_sts_t sts,
  output rpe_pkg::rpe_cmd_t cmd
);

  import rpe_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RDR  = 3'd1;
  localparam logic [2:0] S_RDL  = 3'd2;
  localparam logic [2:0] S_EXEC = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_WB   = 3'd5;
  localparam logic [2:0] S_EMIT = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic [1:0] op;
  logic [1:0] op_next;
  logic       is_digit;
  logic       is_op;
  logic [1:0] op_dec;

  // character decode
  always_comb begin
    is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
    is_op    = 1'b1;
    op_dec   = OP_ADD;
    case (char_code)
      CH_PLUS:  op_dec = OP_ADD;
      CH_MINUS: op_dec = OP_SUB;
      CH_STAR:  op_dec = OP_MUL;
      CH_SLASH: op_dec = OP_DIV;
      default:  is_op = 1'b0;
    endcase
  end

  assign in_stall = (state != S_IDLE);

  // sequencer
  always_comb begin
    state_next = state;
    op_next    = op;
    cmd        = '0;
    cmd.op     = op;
    cmd.digit  = char_code[3:0];
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (is_digit) begin
            cmd.acc_digit = 1'b1;
          end else if (char_code == CH_DOT) begin
            cmd.push_acc = 1'b1;
          end else if (is_op) begin
            if (sts.sp_lt2) begin
              cmd.push_zero = 1'b1;
            end else begin
              op_next    = op_dec;
              state_next = S_RDR;
            end
          end else if (char_code == CH_AT) begin
            state_next = S_EMIT;
          end
        end
      end
      S_RDR: begin
        cmd.rd_sel    = 1'b1;
        cmd.lat_right = 1'b1;
        state_next    = S_RDL;
      end
      S_RDL: begin
        cmd.lat_left = 1'b1;
        state_next   = S_EXEC;
      end
      S_EXEC: begin
        if (op == OP_DIV) begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end else begin
          cmd.exec   = 1'b1;
          state_next = S_WB;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.div_fix = 1'b1;
          state_next  = S_WB;
        end
      end
      S_WB: begin
        cmd.wb     = 1'b1;
        state_next = S_IDLE;
      end
      S_EMIT: begin
        if (!out_valid || !out_stall) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state, operator and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      op        <= OP_ADD;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      op    <= op_next;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || !out_stall))
    else $error("output register overwritten while stalled");

  a_op_read: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && in_valid && is_op && !sts.sp_lt2) |=> state == S_RDR)
    else $error("operator with two operands did not start operand read");

  a_div_latency: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |=> !sts.div_done)
    else $error("divider finished without iterating");
`endif

endmodule

// File: rtl/core/postfix_expression_evaluator.sv
// Postfix expression evaluator: one ASCII character per input transaction.
// Digits build a wrapping 32-bit number, '.' pushes it onto the operand
// stack, + - * / pop two operands and push the result (earlier operand on
// the left, division truncates toward zero), and '@' produces one output
// transaction with the top of stack (0 when empty) and the first error of
// the expression, then clears for the next one. Digits, '.', ignored
// characters and operators with fewer than two operands are taken without
// stalling the input. An add, subtract or multiply stalls the input through
// the two operand reads from the single-read-port stack memory, the result
// register and the write back. A divide passes through the same operand
// reads, start and write back around the restoring divider, which retires
// one quotient bit per cycle and flags done once the last bit is in.
// '@' waits while a previous result is stalled in the output register.
module postfix_expression_evaluator #(
  parameter int STACK_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         char_code,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] value,
  output logic [1:0]         error_code
);

  import rpe_pkg::*;

  rpe_cmd_t cmd;
  rpe_sts_t sts;

  rpe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .char_code (char_code),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  rpe_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .value      (value),
    .error_code (error_code)
  );

endmodule
